// ----- src/bb3_pkg.sv -----
// Shared types, constants and codes for the 3x3 RGB box blur core.
package bb3_pkg;

  // Default line store depth in pixels
  localparam int DEF_MAX_WIDTH = 1024;

  // Field widths
  localparam int CH_W      = 8;
  localparam int WCFG_W    = 11;
  localparam int HCFG_W    = 16;
  localparam int PEND_W    = 11;
  localparam int NUM_BANKS = 4;
  localparam int BANK_W    = 2;
  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;

  // Input op codes
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // Register indexes (paddr[2])
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // Register reset values
  localparam logic [WCFG_W-1:0] WIDTH_RST  = 11'd640;
  localparam logic [HCFG_W-1:0] HEIGHT_RST = 16'd480;

  // Read port slots of the line stores
  localparam int COL_CTR = 0;
  localparam int COL_RGT = 1;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pix_t;

  // Per-result window control handed from the sequencer to the datapath
  typedef struct packed {
    logic [BANK_W-1:0] bank_mid;
    logic              has_top;
    logic              has_bot;
    logic              has_left;
    logic              has_right;
    logic              frame_end;
  } win_ctl_t;

  // Center and right column reads of every bank
  typedef pix_t [1:0] pix_pair_t;

endpackage

// ----- src/bb3_ctrl.sv -----
// Frame position counters, pending result count and window control.
module bb3_ctrl #(
  parameter int MAX_WIDTH = bb3_pkg::DEF_MAX_WIDTH
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  acc,
  input  logic                                  op,
  input  logic                                  restart,
  input  logic [bb3_pkg::WCFG_W-1:0]            uw,
  input  logic [bb3_pkg::HCFG_W-1:0]            uh,
  output logic                                  pix,
  output logic [bb3_pkg::BANK_W-1:0]            wr_bank,
  output logic [$clog2(MAX_WIDTH)-1:0]          wr_addr,
  output logic                                  emit,
  output bb3_pkg::win_ctl_t                     ctl,
  output logic [$clog2(MAX_WIDTH)-1:0]          rd_addr_ctr,
  output logic [$clog2(MAX_WIDTH)-1:0]          rd_addr_rgt
);
  import bb3_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);

  logic [COL_W-1:0]  in_col_r, in_col_nxt;
  logic [HCFG_W-1:0] in_row_r, in_row_nxt;
  logic [COL_W-1:0]  out_col_r, out_col_nxt;
  logic [HCFG_W-1:0] out_row_r, out_row_nxt;
  logic [PEND_W-1:0] pend_r, pend_nxt;

  logic              first, in_last_col, in_last_row;
  logic              out_last_col, out_last_row;
  logic [PEND_W-1:0] pend_base, pend_add;
  logic [PEND_W:0]   delta, pend_sum;
  logic [COL_W-1:0]  ocol_base;
  logic [HCFG_W-1:0] orow_base;

  // Input side: where this pixel lands and how many results it frees
  always_comb begin
    pix         = (op == OP_PIXEL);
    first       = (in_row_r == '0) && (in_col_r == '0);
    in_last_col = (32'(in_col_r) == (32'(uw) - 32'd1));
    in_last_row = (in_row_r == (uh - 16'd1));

    // first pixel of a frame drops whatever the last frame left behind
    pend_base = (pix && first) ? '0 : pend_r;
    ocol_base = (pix && first) ? '0 : out_col_r;
    orow_base = (pix && first) ? '0 : out_row_r;

    delta = '0;
    if (pix && (in_row_r != '0)) begin
      if (in_last_col && in_last_row) begin
        delta = 12'(uw) + 12'd2;
      end else if (in_last_col) begin
        delta = 12'd2;
      end else if (in_col_r != '0) begin
        delta = 12'd1;
      end
    end
    pend_sum = 12'(pend_base) + delta;
    pend_add = pend_sum[PEND_W-1:0];

    emit     = (pend_add != '0);
    pend_nxt = emit ? (pend_add - 11'd1) : pend_add;

    in_col_nxt = in_col_r;
    in_row_nxt = in_row_r;
    if (pix) begin
      if (in_last_col) begin
        in_col_nxt = '0;
        in_row_nxt = in_last_row ? '0 : (in_row_r + 16'd1);
      end else begin
        in_col_nxt = in_col_r + COL_W'(1);
      end
    end
  end

  // Output side: position and neighborhood of the result emitted now
  always_comb begin
    out_last_col = (32'(ocol_base) == (32'(uw) - 32'd1));
    out_last_row = (orow_base == (uh - 16'd1));

    out_col_nxt = ocol_base;
    out_row_nxt = orow_base;
    if (emit) begin
      if (out_last_col) begin
        out_col_nxt = '0;
        out_row_nxt = out_last_row ? '0 : (orow_base + 16'd1);
      end else begin
        out_col_nxt = ocol_base + COL_W'(1);
      end
    end

    ctl.bank_mid  = orow_base[BANK_W-1:0];
    ctl.has_top   = (orow_base != '0);
    ctl.has_bot   = !out_last_row;
    ctl.has_left  = (ocol_base != '0);
    ctl.has_right = !out_last_col;
    ctl.frame_end = out_last_row && out_last_col;

    rd_addr_ctr = ocol_base;
    rd_addr_rgt = out_last_col ? ocol_base : (ocol_base + COL_W'(1));

    wr_bank = in_row_r[BANK_W-1:0];
    wr_addr = in_col_r;
  end

  // Position and count registers; a register write restarts the frame
  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      pend_r    <= '0;
    end else if (acc) begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      pend_r    <= pend_nxt;
    end
  end

  // Positions stay inside the frame
  a_pos_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(in_col_r) < 32'(uw)) && (32'(out_col_r) < 32'(uw)) && (in_row_r < uh))
    else $error("bb3_ctrl: position outside frame");

  // A drain with nothing pending produces no result
  a_drain_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && (op == OP_DRAIN) && (pend_r == '0)) |-> !emit)
    else $error("bb3_ctrl: drain emitted with nothing pending");

  // Register write brings the frame back to its start
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    restart |=> (in_col_r == '0) && (in_row_r == '0) && (pend_r == '0))
    else $error("bb3_ctrl: frame not restarted after register write");

endmodule

// ----- src/bb3_lines.sv -----
// Four row banks with one write and two registered reads, plus write bypass.
module bb3_lines #(
  parameter int MAX_WIDTH = bb3_pkg::DEF_MAX_WIDTH
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          wr_en,
  input  logic [bb3_pkg::BANK_W-1:0]                    wr_bank,
  input  logic [$clog2(MAX_WIDTH)-1:0]                  wr_addr,
  input  bb3_pkg::pix_t                                 wr_data,
  input  logic                                          rd_en,
  input  logic [$clog2(MAX_WIDTH)-1:0]                  rd_addr_ctr,
  input  logic [$clog2(MAX_WIDTH)-1:0]                  rd_addr_rgt,
  output bb3_pkg::pix_pair_t [bb3_pkg::NUM_BANKS-1:0]   rd_q
);
  import bb3_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);

  logic              fwd_vld_r;
  logic [BANK_W-1:0] fwd_bank_r;
  logic [COL_W-1:0]  fwd_addr_r;
  pix_t              fwd_data_r;
  logic [COL_W-1:0]  ra_ctr_r, ra_rgt_r;

  // Remember the write of the last transaction to patch same-cycle reads
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_vld_r <= 1'b0;
    end else if (rd_en) begin
      fwd_vld_r <= wr_en;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_bank_r <= wr_bank;
      fwd_addr_r <= wr_addr;
      fwd_data_r <= wr_data;
      ra_ctr_r   <= rd_addr_ctr;
      ra_rgt_r   <= rd_addr_rgt;
    end
  end

  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    pix_t bank_mem [MAX_WIDTH];
    pix_t q_ctr_r, q_rgt_r;
    logic hit_ctr, hit_rgt;

    // Read-before-write storage of one row
    always_ff @(posedge clk) begin
      if (wr_en && (wr_bank == BANK_W'(b))) begin
        bank_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
        q_ctr_r <= bank_mem[rd_addr_ctr];
        q_rgt_r <= bank_mem[rd_addr_rgt];
      end
    end

    assign hit_ctr = fwd_vld_r && (fwd_bank_r == BANK_W'(b)) && (fwd_addr_r == ra_ctr_r);
    assign hit_rgt = fwd_vld_r && (fwd_bank_r == BANK_W'(b)) && (fwd_addr_r == ra_rgt_r);

    assign rd_q[b][COL_CTR] = hit_ctr ? fwd_data_r : q_ctr_r;
    assign rd_q[b][COL_RGT] = hit_rgt ? fwd_data_r : q_rgt_r;
  end

endmodule

// ----- src/bb3_avg.sv -----
// Window column sums, rounded average per channel and result register.
module bb3_avg (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          ld,
  input  bb3_pkg::win_ctl_t                             ctl,
  input  bb3_pkg::pix_pair_t [bb3_pkg::NUM_BANKS-1:0]   rd_q,
  output logic                                          s1_free,
  input  logic                                          out_ready,
  output logic                                          out_valid,
  output logic [bb3_pkg::CH_W-1:0]                      out_red,
  output logic [bb3_pkg::CH_W-1:0]                      out_green,
  output logic [bb3_pkg::CH_W-1:0]                      out_blue,
  output logic                                          out_frame_end
);
  import bb3_pkg::*;

  typedef enum logic [1:0] {DIV4, DIV6, DIV9} div_t;

  typedef struct packed {
    logic [9:0] red;
    logic [9:0] green;
    logic [9:0] blue;
  } csum_t;

  typedef struct packed {
    logic [11:0] red;
    logic [11:0] green;
    logic [11:0] blue;
  } tsum_t;

  localparam int          RCP_SH = 15;
  localparam logic [12:0] RCP6   = 13'd5462;
  localparam logic [12:0] RCP9   = 13'd3641;

  // Rounded (s + n/2) / n: by shift for n = 4, by reciprocal multiply for 6 and 9
  function automatic logic [CH_W-1:0] div_round(logic [11:0] s, div_t d);
    logic [12:0] x;
    logic [25:0] p;
    logic [12:0] q;
    x = '0;
    p = '0;
    q = '0;
    case (d)
      DIV4: begin
        x = 13'(s) + 13'd2;
        q = x >> 2;
      end
      DIV6: begin
        x = 13'(s) + 13'd3;
        p = 26'(x) * 26'(RCP6);
        q = p[RCP_SH +: 13];
      end
      DIV9: begin
        x = 13'(s) + 13'd4;
        p = 26'(x) * 26'(RCP9);
        q = p[RCP_SH +: 13];
      end
      default: q = '0;
    endcase
    return q[CH_W-1:0];
  endfunction

  logic     s1_valid_r, s2_valid_r, out_valid_r;
  win_ctl_t s1_ctl_r;
  csum_t    left_sum_r;
  tsum_t    s2_sum_r;
  div_t     s2_div_r;
  logic     s2_fe_r;
  pix_t     out_pix_r;
  logic     out_fe_r;

  logic              out_free, s2_free;
  logic [BANK_W-1:0] bank_top, bank_bot;
  csum_t             col [2];
  csum_t             lft, rgt;
  tsum_t             tot;
  div_t              div_sel;
  pix_t              pt, pm, pb;

  // Stage handshake: each stage moves when the one after it has room
  assign out_free = !out_valid_r || out_ready;
  assign s2_free  = !s2_valid_r || out_free;
  assign s1_free  = !s1_valid_r || s2_free;

  // Column sums over the rows present, then the three-column total and the divisor choice
  always_comb begin
    bank_top = s1_ctl_r.bank_mid - BANK_W'(1);
    bank_bot = s1_ctl_r.bank_mid + BANK_W'(1);
    for (int p = 0; p < 2; p++) begin
      pt = s1_ctl_r.has_top ? rd_q[bank_top][p] : '0;
      pm = rd_q[s1_ctl_r.bank_mid][p];
      pb = s1_ctl_r.has_bot ? rd_q[bank_bot][p] : '0;
      col[p].red   = 10'(pt.red)   + 10'(pm.red)   + 10'(pb.red);
      col[p].green = 10'(pt.green) + 10'(pm.green) + 10'(pb.green);
      col[p].blue  = 10'(pt.blue)  + 10'(pm.blue)  + 10'(pb.blue);
    end
    lft = s1_ctl_r.has_left  ? left_sum_r   : '0;
    rgt = s1_ctl_r.has_right ? col[COL_RGT] : '0;
    tot.red   = 12'(lft.red)   + 12'(col[COL_CTR].red)   + 12'(rgt.red);
    tot.green = 12'(lft.green) + 12'(col[COL_CTR].green) + 12'(rgt.green);
    tot.blue  = 12'(lft.blue)  + 12'(col[COL_CTR].blue)  + 12'(rgt.blue);

    if ((s1_ctl_r.has_top && s1_ctl_r.has_bot) && (s1_ctl_r.has_left && s1_ctl_r.has_right)) begin
      div_sel = DIV9;
    end else if ((s1_ctl_r.has_top && s1_ctl_r.has_bot) ||
                 (s1_ctl_r.has_left && s1_ctl_r.has_right)) begin
      div_sel = DIV6;
    end else begin
      div_sel = DIV4;
    end
  end

  // Stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid_r <= ld;
      end
      if (s2_free) begin
        s2_valid_r <= s1_valid_r;
      end
      if (out_free) begin
        out_valid_r <= s2_valid_r;
      end
    end
  end

  // Stage payload; the center column sum becomes the next result's left column
  always_ff @(posedge clk) begin
    if (s1_free) begin
      s1_ctl_r <= ctl;
    end
    if (s1_valid_r && s2_free) begin
      left_sum_r <= col[COL_CTR];
    end
    if (s2_free) begin
      s2_sum_r <= tot;
      s2_div_r <= div_sel;
      s2_fe_r  <= s1_ctl_r.frame_end;
    end
    if (out_free) begin
      out_pix_r.red   <= div_round(s2_sum_r.red, s2_div_r);
      out_pix_r.green <= div_round(s2_sum_r.green, s2_div_r);
      out_pix_r.blue  <= div_round(s2_sum_r.blue, s2_div_r);
      out_fe_r        <= s2_fe_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_red       = out_pix_r.red;
  assign out_green     = out_pix_r.green;
  assign out_blue      = out_pix_r.blue;
  assign out_frame_end = out_fe_r;

  // Input is held off only when every stage is full and the output is stalled
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_free |-> s1_valid_r && s2_valid_r && out_valid_r && !out_ready)
    else $error("bb3_avg: input held off with room in the pipeline");

  // A result stuck at the output keeps the stage behind it from moving
  a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid_r && out_valid_r && !out_ready) |=> s2_valid_r)
    else $error("bb3_avg: stage two lost a result during stall");

endmodule

// ----- src/box_blur_3x3_rgb_core.sv -----
// Top level of the streaming 3x3 RGB box blur with its APB register port.
//
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------------------------
//  in       | in_valid / in_ready    | in_op, in_red, in_green, in_blue
//  out      | out_valid / out_ready  | out_red, out_green, out_blue, out_frame_end
//  config   | psel, penable, pwrite  | paddr, pwdata, prdata (pready tied high)
//
// One input transaction per clock while in_ready is high; each line bank does at most one write and two reads a cycle.
// A result passes from the transaction that emits it through stage one and stage two into the output register.
// Results trail the pixel stream by about one row; drain transactions flush the rest.
// rst_n clears positions, counts and stage valids; row banks are not cleared.
// in_ready drops only when all three pipeline stages hold results and out_ready is low.
module box_blur_3x3_rgb_core #(
  parameter int MAX_WIDTH = bb3_pkg::DEF_MAX_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_op,
  input  logic [bb3_pkg::CH_W-1:0]      in_red,
  input  logic [bb3_pkg::CH_W-1:0]      in_green,
  input  logic [bb3_pkg::CH_W-1:0]      in_blue,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bb3_pkg::CH_W-1:0]      out_red,
  output logic [bb3_pkg::CH_W-1:0]      out_green,
  output logic [bb3_pkg::CH_W-1:0]      out_blue,
  output logic                          out_frame_end,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bb3_pkg::APB_AW-1:0]    paddr,
  input  logic [bb3_pkg::APB_DW-1:0]    pwdata,
  output logic [bb3_pkg::APB_DW-1:0]    prdata,
  output logic                          pready
);
  import bb3_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);

  logic [WCFG_W-1:0] width_r;
  logic [HCFG_W-1:0] height_r;
  logic [WCFG_W-1:0] uw;
  logic [HCFG_W-1:0] uh;
  logic              cfg_wr, acc;

  logic              pix, emit;
  logic [BANK_W-1:0] wr_bank;
  logic [COL_W-1:0]  wr_addr, rd_addr_ctr, rd_addr_rgt;
  win_ctl_t          ctl;
  pix_t              in_pix;
  pix_pair_t [NUM_BANKS-1:0] rd_q;
  logic              s1_free;

  // APB register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_WIDTH:  width_r  <= pwdata[WCFG_W-1:0];
        REG_HEIGHT: height_r <= pwdata[HCFG_W-1:0];
        default:    width_r  <= width_r;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_WIDTH:  prdata = APB_DW'(width_r);
      REG_HEIGHT: prdata = APB_DW'(height_r);
      default:    prdata = '0;
    endcase
  end

  // Frame size as used: width clamped to 2..MAX_WIDTH, height to at least 2
  always_comb begin
    if (width_r < 11'd2) begin
      uw = 11'd2;
    end else if (32'(width_r) > 32'(MAX_WIDTH)) begin
      uw = WCFG_W'(MAX_WIDTH);
    end else begin
      uw = width_r;
    end
    uh = (height_r < 16'd2) ? 16'd2 : height_r;
  end

  assign in_ready = s1_free;
  assign acc      = in_valid && in_ready;

  assign in_pix.red   = in_red;
  assign in_pix.green = in_green;
  assign in_pix.blue  = in_blue;

  bb3_ctrl #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc         (acc),
    .op          (in_op),
    .restart     (cfg_wr),
    .uw          (uw),
    .uh          (uh),
    .pix         (pix),
    .wr_bank     (wr_bank),
    .wr_addr     (wr_addr),
    .emit        (emit),
    .ctl         (ctl),
    .rd_addr_ctr (rd_addr_ctr),
    .rd_addr_rgt (rd_addr_rgt)
  );

  bb3_lines #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_lines (
    .clk         (clk),
    .rst_n       (rst_n),
    .wr_en       (acc && pix),
    .wr_bank     (wr_bank),
    .wr_addr     (wr_addr),
    .wr_data     (in_pix),
    .rd_en       (acc),
    .rd_addr_ctr (rd_addr_ctr),
    .rd_addr_rgt (rd_addr_rgt),
    .rd_q        (rd_q)
  );

  bb3_avg u_avg (
    .clk           (clk),
    .rst_n         (rst_n),
    .ld            (acc && emit),
    .ctl           (ctl),
    .rd_q          (rd_q),
    .s1_free       (s1_free),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .out_frame_end (out_frame_end)
  );

endmodule
